@@ rtl/core/mr_pkg.sv @@
// mr_pkg: shared constants and types for the miller-rabin round block
// no dependencies
package mr_pkg;
   localparam int NUM_WIDTH = 64;
   localparam int CNT_WIDTH = $clog2(NUM_WIDTH + 1);
   localparam int BIT_WIDTH = $clog2(NUM_WIDTH);

   typedef logic [NUM_WIDTH-1:0] num_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_SPLIT,
      ST_SQ_START,
      ST_SQ_WAIT,
      ST_MUL_START,
      ST_MUL_WAIT,
      ST_CHECK,
      ST_LOOP_START,
      ST_LOOP_WAIT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } mul_ctl_type;
endpackage

@@ rtl/core/mr_modmul.sv @@
// mr_modmul: shift-add modular multiplier, one multiplier bit per cycle
// depends on mr_pkg
module mr_modmul (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  mr_pkg::num_type     x,
   input  mr_pkg::num_type     y,
   input  mr_pkg::num_type     n,
   output mr_pkg::num_type     product,
   output logic                done
);
   mr_pkg::num_type acc_ff, acc_in;
   mr_pkg::num_type y_ff, y_in;
   logic [mr_pkg::CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [mr_pkg::NUM_WIDTH:0] dbl, dbl_red, sum;
   mr_pkg::num_type stage1;

   always_comb begin
      dbl = {acc_ff, 1'b0};
      dbl_red = (dbl >= {1'b0, n}) ? dbl - {1'b0, n} : dbl;
      stage1 = dbl_red[mr_pkg::NUM_WIDTH-1:0];
      sum = {1'b0, stage1} + {1'b0, x};
      if (sum >= {1'b0, n}) begin
         sum = sum - {1'b0, n};
      end
      acc_in = acc_ff;
      y_in = y_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in = '0;
         y_in = y;
         cnt_in = mr_pkg::CNT_WIDTH'(mr_pkg::NUM_WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = y_ff[mr_pkg::NUM_WIDTH-1] ? sum[mr_pkg::NUM_WIDTH-1:0] : stage1;
         y_in = {y_ff[mr_pkg::NUM_WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == mr_pkg::CNT_WIDTH'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff <= acc_in;
      y_ff   <= y_in;
   end

   assign product = acc_ff;
   assign done = done_ff;

`ifndef SYNTHESIS
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("done without busy");
   a_no_done_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("done while busy");
   a_acc_below_n: assert property (@(posedge clock) disable iff (reset)
      (done_ff && n != '0) |-> acc_ff < n) else $error("product not reduced");
`endif
endmodule

@@ rtl/core/miller_rabin_round.sv @@
// miller_rabin_round: one miller-rabin round on a shared modular multiplier
// depends on mr_pkg, mr_modmul
//
// channel | dir | payload
// req     | in  | tdata[63:0] candidate, tdata[127:64] witness
// rsp     | out | tdata[0] probable_prime, tdata[1] bad_candidate (8 bits)
//
// one item takes the base reduction, the split of n-1 into m and k, 64 squarings
// plus one multiply per set bit of m, and up to k trailing squarings; a candidate
// of zero or one goes straight to the result. the reduction, squarings and
// multiplies all run on the single shift-add modular multiplier
// req_tready is high only in idle; a result waits in rsp until taken
// reset is synchronous, active high, and clears control state only
module miller_rabin_round (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // candidate, witness
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [7:0]   rsp_tdata    // probable_prime, bad_candidate, zero pad
);
   mr_pkg::state_type state_ff, state_in;
   mr_pkg::num_type n_ff, n_in, a_ff, a_in, b_ff, b_in, m_ff, m_in, nm1;
   logic [mr_pkg::BIT_WIDTH-1:0] bit_ff, bit_in;
   logic [mr_pkg::CNT_WIDTH-1:0] k_ff, k_in;
   logic pass_ff, pass_in, bad_ff, bad_in;
   mr_pkg::num_type mx, my, prod;
   logic mdone;
   mr_pkg::mul_ctl_type mctl;

   assign nm1 = n_ff - 1'b1;

   mr_modmul u_mul (
      .clock(clock), .reset(reset), .start(mctl.start),
      .x(mx), .y(my), .n(n_ff), .product(prod), .done(mdone)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mr_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tdata[mr_pkg::NUM_WIDTH-1:0] == '0 ||
                   req_tdata[mr_pkg::NUM_WIDTH-1:0] == mr_pkg::num_type'(1)) begin
                  state_in = mr_pkg::ST_DONE;
               end else begin
                  state_in = mr_pkg::ST_REDUCE;
               end
            end
         end
         mr_pkg::ST_REDUCE: if (mdone) state_in = mr_pkg::ST_SPLIT;
         mr_pkg::ST_SPLIT: if (m_ff[0]) state_in = mr_pkg::ST_SQ_START;
         mr_pkg::ST_SQ_START: state_in = mr_pkg::ST_SQ_WAIT;
         mr_pkg::ST_SQ_WAIT: begin
            if (mdone) begin
               if (m_ff[bit_ff]) state_in = mr_pkg::ST_MUL_START;
               else if (bit_ff == '0) state_in = mr_pkg::ST_CHECK;
               else state_in = mr_pkg::ST_SQ_START;
            end
         end
         mr_pkg::ST_MUL_START: state_in = mr_pkg::ST_MUL_WAIT;
         mr_pkg::ST_MUL_WAIT: begin
            if (mdone) begin
               if (bit_ff == '0) state_in = mr_pkg::ST_CHECK;
               else state_in = mr_pkg::ST_SQ_START;
            end
         end
         mr_pkg::ST_CHECK: begin
            if (pass_ff || k_ff == '0 || b_ff == nm1) begin
               state_in = mr_pkg::ST_DONE;
            end else begin
               state_in = mr_pkg::ST_LOOP_START;
            end
         end
         mr_pkg::ST_LOOP_START: state_in = mr_pkg::ST_LOOP_WAIT;
         mr_pkg::ST_LOOP_WAIT: if (mdone) state_in = mr_pkg::ST_CHECK;
         mr_pkg::ST_DONE: if (rsp_tready) state_in = mr_pkg::ST_IDLE;
         default: state_in = mr_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      n_in = n_ff; a_in = a_ff; b_in = b_ff; m_in = m_ff;
      bit_in = bit_ff; k_in = k_ff; pass_in = pass_ff; bad_in = bad_ff;
      mctl = '0;
      mx = b_ff;
      my = b_ff;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (state_ff)
         mr_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               n_in = req_tdata[mr_pkg::NUM_WIDTH-1:0];
               a_in = req_tdata[64 +: mr_pkg::NUM_WIDTH];
               bad_in = (req_tdata[mr_pkg::NUM_WIDTH-1:0] == '0);
               pass_in = 1'b0;
               k_in = '0;
               mctl.start = 1'b1;
               // a mod n computed as 1 * a mod n, scanning the bits of a
               mx = mr_pkg::num_type'(1);
               my = req_tdata[64 +: mr_pkg::NUM_WIDTH];
            end
         end
         mr_pkg::ST_REDUCE: begin
            mctl.busy = 1'b1;
            mx = mr_pkg::num_type'(1);
            my = a_ff;
            if (mdone) begin
               a_in = prod;
               m_in = nm1;
               b_in = mr_pkg::num_type'(1);
               bit_in = mr_pkg::BIT_WIDTH'(mr_pkg::NUM_WIDTH - 1);
            end
         end
         mr_pkg::ST_SPLIT: begin
            if (!m_ff[0]) begin
               m_in = m_ff >> 1;
               k_in = k_ff + 1'b1;
            end
         end
         mr_pkg::ST_SQ_START: mctl.start = 1'b1;
         mr_pkg::ST_SQ_WAIT: begin
            if (mdone) begin
               b_in = prod;
               if (!m_ff[bit_ff] && bit_ff != '0) bit_in = bit_ff - 1'b1;
               // a^m of one passes at once
               if (!m_ff[bit_ff] && bit_ff == '0) pass_in = (prod == mr_pkg::num_type'(1));
            end
         end
         mr_pkg::ST_MUL_START: begin
            mctl.start = 1'b1;
            mx = a_ff;
         end
         mr_pkg::ST_MUL_WAIT: begin
            mx = a_ff;
            if (mdone) begin
               b_in = prod;
               if (bit_ff != '0) bit_in = bit_ff - 1'b1;
               else pass_in = (prod == mr_pkg::num_type'(1));
            end
         end
         mr_pkg::ST_CHECK: begin
            if (k_ff != '0 && b_ff == nm1) begin
               pass_in = 1'b1;
            end
         end
         mr_pkg::ST_LOOP_START: mctl.start = 1'b1;
         mr_pkg::ST_LOOP_WAIT: begin
            if (mdone) begin
               b_in = prod;
               k_in = k_ff - 1'b1;
            end
         end
         mr_pkg::ST_DONE: rsp_tvalid = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      n_ff <= n_in; a_ff <= a_in; b_ff <= b_in; m_ff <= m_in;
      bit_ff <= bit_in; k_ff <= k_in; pass_ff <= pass_in; bad_ff <= bad_in;
   end

   assign rsp_tdata = {6'b0, bad_ff, pass_ff};

`ifndef SYNTHESIS
   a_bad_not_prime: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(bad_ff && pass_ff)) else $error("bad candidate passed");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped");
   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != mr_pkg::ST_IDLE) |-> !req_tready) else $error("ready while busy");
   a_mul_idle: assert property (@(posedge clock) disable iff (reset)
      mctl.start |-> (state_ff != mr_pkg::ST_DONE)) else $error("multiply in done");
`endif
endmodule
